// File: rtl/daq_pkg.sv
// Shared types, codes and defaults for the dedup two-lane job queue.
// No dependencies.
package daq_pkg;

  localparam int LaneDepthDef  = 64;
  localparam int KeyEntriesDef = 128;
  localparam int WorkersDef    = 32;

  localparam logic [7:0] PickIntervalRst    = 8'd8;
  localparam logic [7:0] StarvationLimitRst = 8'd24;

  localparam logic [2:0] OP_PUSH     = 3'd0;
  localparam logic [2:0] OP_POP      = 3'd1;
  localparam logic [2:0] OP_COMPLETE = 3'd2;
  localparam logic [2:0] OP_REMOVE   = 3'd3;
  localparam logic [2:0] OP_STOP     = 3'd4;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_STOPPED = 3'd4;
  localparam logic [2:0] ST_GIVEN   = 3'd5;

  localparam logic CFG_PICK_INTERVAL    = 1'b0;
  localparam logic CFG_STARVATION_LIMIT = 1'b1;

  // Lane entry: kind in tag bit 32, handle below.
  typedef struct packed {
    logic [32:0] tag;
    logic [63:0] hash;
  } entry_t;

  // Command broadcast to every cell of a lane; data is the push entry or purge tag.
  typedef struct packed {
    logic   push;
    logic   purge;
    logic   pop;
    entry_t data;
  } lane_cmd_t;

endpackage

// File: rtl/daq_if.sv
// Valid/ready channel interfaces for job requests and results.
// Depends on nothing.
interface daq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [4:0]  worker_id;
  logic        job_kind;
  logic [31:0] pipeline_handle;
  logic [63:0] state_hash;
  logic        is_low_priority;

  modport source (output valid, operation, worker_id, job_kind, pipeline_handle,
                  state_hash, is_low_priority, input ready);
  modport sink (input valid, operation, worker_id, job_kind, pipeline_handle,
                state_hash, is_low_priority, output ready);
endinterface

interface daq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        out_kind;
  logic [31:0] out_handle;
  logic [63:0] out_hash;
  logic        from_background;

  modport source (output valid, status, out_kind, out_handle, out_hash, from_background,
                  input ready);
  modport sink (input valid, status, out_kind, out_handle, out_hash, from_background,
                output ready);
endinterface

// File: rtl/daq_lane_cell.sv
// One slot of a shift-register lane; moves its entry toward the head into a hole.
// Depends on daq_pkg.
module daq_lane_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_i,
  input  daq_pkg::lane_cmd_t cmd_i,
  input  logic               prev_valid_i,
  input  logic               next_valid_i,
  input  daq_pkg::entry_t    next_entry_i,
  output logic               valid_o,
  output daq_pkg::entry_t    entry_o
);
  import daq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.pop && head_i) begin
      valid_d = 1'b0;
    end else if (cmd_i.purge && valid_q && entry_q.tag == cmd_i.data.tag) begin
      valid_d = 1'b0;
    end else if (cmd_i.push && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      entry_d = cmd_i.data;
    end else if (!valid_q && next_valid_i) begin
      valid_d = 1'b1;
      entry_d = next_entry_i;
    end else if (valid_q && !prev_valid_i) begin
      // left neighbor is a hole and takes this entry
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
endmodule

// File: rtl/daq_lane.sv
// A lane: a row of lane cells, head at cell 0, holes collapse one step a cycle.
// Depends on daq_pkg and daq_lane_cell.
module daq_lane #(
  parameter int LANE_DEPTH = daq_pkg::LaneDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  daq_pkg::lane_cmd_t cmd_i,
  output logic               head_valid_o,
  output daq_pkg::entry_t    head_entry_o,
  output logic               full_o,
  output logic               settled_o
);
  import daq_pkg::*;

  logic   [LANE_DEPTH-1:0] valid;
  entry_t                  entry [LANE_DEPTH];
  logic   [LANE_DEPTH-1:0] prev_valid, next_valid;
  entry_t                  next_entry [LANE_DEPTH];

  for (genvar i = 0; i < LANE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
    end else begin : g_body
      assign prev_valid[i] = valid[i-1];
    end
    if (i == LANE_DEPTH - 1) begin : g_tail
      assign next_valid[i] = 1'b0;
      assign next_entry[i] = entry[i];
    end else begin : g_mid
      assign next_valid[i] = valid[i+1];
      assign next_entry[i] = entry[i+1];
    end
    daq_lane_cell u_cell (
      .clk_i,
      .rst_ni,
      .head_i       (i == 0),
      .cmd_i,
      .prev_valid_i (prev_valid[i]),
      .next_valid_i (next_valid[i]),
      .next_entry_i (next_entry[i]),
      .valid_o      (valid[i]),
      .entry_o      (entry[i])
    );
  end

  assign head_valid_o = valid[0];
  assign head_entry_o = entry[0];
  assign full_o       = valid[LANE_DEPTH-1];
  // settled when valid cells form a prefix
  assign settled_o    = ~|(~valid & {1'b0, valid[LANE_DEPTH-1:1]});
endmodule

// File: rtl/daq_key_cell.sv
// One dedupe key slot with its own comparators.
// Depends on daq_pkg.
module daq_key_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  daq_pkg::entry_t cmp_i,
  input  logic            set_i,
  input  logic            clr_i,
  output logic            valid_o,
  output logic            hit_o,
  output logic            tag_hit_o
);
  import daq_pkg::*;

  logic   valid_q;
  entry_t key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)    valid_q <= 1'b0;
    else if (set_i) valid_q <= 1'b1;
    else if (clr_i) valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (set_i) key_q <= cmp_i;
  end

  assign valid_o   = valid_q;
  assign tag_hit_o = valid_q && key_q.tag == cmp_i.tag;
  assign hit_o     = tag_hit_o && key_q.hash == cmp_i.hash;
endmodule

// File: rtl/daq_mod_unit.sv
// Bit-serial remainder of a 32-bit pick number by an 8-bit interval.
// Depends on nothing.
module daq_mod_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        done_o,
  output logic        zero_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [7:0]  rem_q;
  logic [8:0]  trial;

  assign trial = {rem_q, dvd_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) rem_q <= 8'(trial - {1'b0, divisor_i});
      else                            rem_q <= trial[7:0];
    end
  end

  assign done_o = done_q;
  assign zero_o = rem_q == 8'd0;
endmodule

// File: rtl/dedup_two_lane_job_queue.sv
// Two-lane job queue: push, pop, complete, remove and stop requests in, one status beat out
// per request. Depends on daq_pkg, daq_if, daq_lane, daq_key_cell and daq_mod_unit.
// A request passes the eval, act and finish states and waits for a free output register; a pop
// that reaches a lane also runs the bit-serial pick-interval remainder. After a pop or a remove
// the lanes close holes one cell per cycle; the next request waits until both lanes are compact.
module dedup_two_lane_job_queue #(
  parameter int LANE_DEPTH  = daq_pkg::LaneDepthDef,
  parameter int KEY_ENTRIES = daq_pkg::KeyEntriesDef,
  parameter int WORKERS     = daq_pkg::WorkersDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  daq_in_if.sink     job_i,
  daq_out_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import daq_pkg::*;

  localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state_q;
  logic [7:0]  interval_q, limit_q;
  logic        stop_q;
  logic [31:0] next_start_q;

  logic [2:0]    op_q;
  logic [WW-1:0] wid_q;
  entry_t        cur_q;
  logic          low_q;

  logic [KEY_ENTRIES-1:0] key_v, key_hit, key_thit, key_set, key_clr;
  logic [KEY_ENTRIES-1:0] hit_q, thit_q, free_oh_q;
  logic                   key_full_q;

  logic [31:0] pick_q [WORKERS];
  logic [WORKERS-1:0] pick_v_q;
  logic [7:0]  starv_q [WORKERS];

  lane_cmd_t live_cmd, back_cmd;
  logic      live_hv, back_hv, live_full, back_full, live_ok, back_ok;
  entry_t    live_he, back_he;

  logic [2:0] st_q;
  entry_t     res_e_q;
  logic       res_bg_q;
  logic       out_vq;
  logic [2:0] out_st_q;
  entry_t     out_e_q;
  logic       out_bg_q;
  logic       out_load;

  logic        mod_start, mod_done, mod_zero;
  logic [31:0] pick_cur;
  logic        dup, push_ok, pref, take_live;

  // key table cells
  for (genvar k = 0; k < KEY_ENTRIES; k++) begin : g_key
    daq_key_cell u_key (
      .clk_i,
      .rst_ni,
      .cmp_i     (cur_q),
      .set_i     (key_set[k]),
      .clr_i     (key_clr[k]),
      .valid_o   (key_v[k]),
      .hit_o     (key_hit[k]),
      .tag_hit_o (key_thit[k])
    );
  end

  daq_lane #(.LANE_DEPTH(LANE_DEPTH)) u_live (
    .clk_i, .rst_ni, .cmd_i(live_cmd), .head_valid_o(live_hv), .head_entry_o(live_he),
    .full_o(live_full), .settled_o(live_ok)
  );

  daq_lane #(.LANE_DEPTH(LANE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_i(back_cmd), .head_valid_o(back_hv), .head_entry_o(back_he),
    .full_o(back_full), .settled_o(back_ok)
  );

  daq_mod_unit u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .dividend_i(pick_cur), .divisor_i(interval_q),
    .done_o(mod_done), .zero_o(mod_zero)
  );

  assign job_i.ready = (state_q == S_IDLE) && live_ok && back_ok;

  assign pick_cur  = pick_v_q[wid_q] ? pick_q[wid_q] : next_start_q;
  assign dup       = |hit_q;
  assign push_ok   = !dup && !key_full_q && !(low_q ? back_full : live_full);
  assign pref      = (interval_q != 8'd0 && mod_zero) || (starv_q[wid_q] >= limit_q);
  assign take_live = !(pref && back_hv) && live_hv;
  assign mod_start = (state_q == S_ACT) && (op_q == OP_POP) && !stop_q && (live_hv || back_hv);
  // finished result moves to the output register once that is free
  assign out_load  = (state_q == S_FIN) && (!out_vq || res_o.ready);

  always_comb begin
    live_cmd       = '0;
    back_cmd       = '0;
    live_cmd.data  = cur_q;
    back_cmd.data  = cur_q;
    key_set        = '0;
    key_clr        = '0;
    if (state_q == S_ACT) begin
      case (op_q)
        OP_PUSH: begin
          if (push_ok) begin
            key_set       = free_oh_q;
            live_cmd.push = !low_q;
            back_cmd.push = low_q;
          end
        end
        OP_COMPLETE: key_clr = hit_q;
        OP_REMOVE: begin
          key_clr        = thit_q;
          live_cmd.purge = 1'b1;
          back_cmd.purge = 1'b1;
        end
        default: ;
      endcase
    end
    if (state_q == S_MOD && mod_done) begin
      live_cmd.pop = take_live;
      back_cmd.pop = !take_live;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= PickIntervalRst;
      limit_q    <= StarvationLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PICK_INTERVAL:    interval_q <= cfg_data_i;
        CFG_STARVATION_LIMIT: limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      stop_q       <= 1'b0;
      next_start_q <= 32'd1;
      pick_v_q     <= '0;
      out_vq       <= 1'b0;
      for (int i = 0; i < WORKERS; i++) starv_q[i] <= '0;
    end else begin
      if (out_load)          out_vq <= 1'b1;
      else if (res_o.ready)  out_vq <= 1'b0;
      case (state_q)
        S_IDLE: if (job_i.valid && job_i.ready) state_q <= S_EVAL;
        S_EVAL: state_q <= S_ACT;
        S_ACT: begin
          if (op_q == OP_STOP) stop_q <= 1'b1;
          if (op_q == OP_POP && !stop_q && (live_hv || back_hv)) state_q <= S_MOD;
          else                                                   state_q <= S_FIN;
          if (op_q == OP_POP && (stop_q || live_hv || back_hv)) begin
            if (!pick_v_q[wid_q]) begin
              pick_v_q[wid_q] <= 1'b1;
              next_start_q    <= next_start_q + 32'd1;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_q <= S_FIN;
            if (take_live && back_hv) begin
              if (starv_q[wid_q] != 8'hFF) starv_q[wid_q] <= starv_q[wid_q] + 8'd1;
            end else begin
              starv_q[wid_q] <= '0;
            end
          end
        end
        S_FIN: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q     <= job_i.operation;
        wid_q    <= WW'(job_i.worker_id % WORKERS);
        cur_q    <= {job_i.job_kind, job_i.pipeline_handle, job_i.state_hash};
        low_q    <= job_i.is_low_priority;
      end
      S_EVAL: begin
        hit_q      <= key_hit;
        thit_q     <= key_thit;
        free_oh_q  <= ~key_v & (key_v + KEY_ENTRIES'(1));
        key_full_q <= &key_v;
      end
      S_ACT: begin
        res_e_q  <= '0;
        res_bg_q <= 1'b0;
        case (op_q)
          OP_PUSH: st_q <= dup ? ST_DUP : (push_ok ? ST_DONE : ST_FULL);
          OP_POP: begin
            if (stop_q || live_hv || back_hv) pick_q[wid_q] <= pick_cur + 32'd1;
            if (stop_q)                       st_q <= ST_STOPPED;
            else if (!live_hv && !back_hv)    st_q <= ST_EMPTY;
            else                              st_q <= ST_DONE;
          end
          default: st_q <= ST_DONE;
        endcase
      end
      S_MOD: begin
        if (mod_done) begin
          st_q     <= ST_GIVEN;
          res_e_q  <= take_live ? live_he : back_he;
          res_bg_q <= !take_live;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_st_q <= st_q;
          out_e_q  <= res_e_q;
          out_bg_q <= res_bg_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid           = out_vq;
  assign res_o.status          = out_st_q;
  assign res_o.out_kind        = out_e_q.tag[32];
  assign res_o.out_handle      = out_e_q.tag[31:0];
  assign res_o.out_hash        = out_e_q.hash;
  assign res_o.from_background = out_bg_q;

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q) else $error("stop flag cleared");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((live_full && live_ok) || (back_full && back_ok)) |-> (live_hv || back_hv))
    else $error("full lane without head");

  a_mod_only_in_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> (op_q == OP_POP && !stop_q)) else $error("remainder outside pop");

  a_given_from_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && mod_done) |-> (live_hv || back_hv)) else $error("pop of empty lanes");
endmodule

// File: dv/tb_top.sv
// Self-checking testbench for dedup_two_lane_job_queue: push, pop, complete, remove and stop.
// A behavioral model of the queue predicts each status beat and a checker compares them.
// Depends on daq_pkg, daq_if and the queue RTL.
module tb_top;
  import daq_pkg::*;

  localparam int LANE_D = 64;
  localparam int KEY_N  = 128;
  localparam int WORK_N = 32;

  typedef struct packed {
    logic [2:0]  status;
    logic        kind;
    logic [31:0] handle;
    logic [63:0] hash;
    logic        bg;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = '0;

  daq_in_if  job_if ();
  daq_out_if res_if ();

  dedup_two_lane_job_queue u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // queue model state
  logic [32:0] live_tag[$];
  logic [63:0] live_hash[$];
  logic [32:0] back_tag[$];
  logic [63:0] back_hash[$];
  logic [32:0] key_tag[KEY_N];
  logic [63:0] key_hash[KEY_N];
  logic        key_vld[KEY_N];
  logic [31:0] start_pick;
  logic [31:0] wpick[WORK_N];
  logic        wpick_vld[WORK_N];
  logic [7:0]  wstarve[WORK_N];
  logic        stopped;
  logic [7:0]  m_interval;
  logic [7:0]  m_limit;

  result_t expected_q[$];
  int      errors = 0;
  int      n_checked = 0;
  int      n_given = 0;
  int      snd_idle = 0;
  int      rcv_idle = 0;
  int      rcv_hold = 0;
  int      idle_cycles = 0;

  // pool of recent keys so duplicates, completes and removes hit
  logic [32:0] pool_tag[16];
  logic [63:0] pool_hash[16];

  function automatic int find_key(logic [32:0] t, logic [63:0] h);
    for (int i = 0; i < KEY_N; i++)
      if (key_vld[i] && key_tag[i] == t && key_hash[i] == h) return i;
    return -1;
  endfunction

  function automatic result_t predict_queue(logic [2:0] op, logic [4:0] wid, logic kind,
                                            logic [31:0] handle, logic [63:0] hash,
                                            logic low);
    result_t r;
    logic [32:0] t;
    int k;
    int w;
    logic [31:0] pick;
    logic pref;
    logic take_live;
    r = '0;
    r.status = ST_DONE;
    t = {kind, handle};
    w = int'(wid) % WORK_N;
    case (op)
      OP_PUSH: begin
        if (find_key(t, hash) >= 0) begin
          r.status = ST_DUP;
        end else begin
          k = -1;
          for (int i = 0; i < KEY_N; i++)
            if (!key_vld[i] && k < 0) k = i;
          if (k < 0 || (low ? back_tag.size() : live_tag.size()) >= LANE_D) begin
            r.status = ST_FULL;
          end else begin
            key_vld[k] = 1'b1;
            key_tag[k] = t;
            key_hash[k] = hash;
            if (low) begin
              back_tag = {back_tag, t};
              back_hash = {back_hash, hash};
            end else begin
              live_tag = {live_tag, t};
              live_hash = {live_hash, hash};
            end
          end
        end
      end
      OP_POP: begin
        if (!stopped && live_tag.size() == 0 && back_tag.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (!wpick_vld[w]) begin
            wpick[w] = start_pick;
            wpick_vld[w] = 1'b1;
            start_pick = start_pick + 1;
          end
          pick = wpick[w];
          wpick[w] = pick + 1;
          if (stopped) begin
            r.status = ST_STOPPED;
          end else begin
            pref = (m_interval != 0 && (pick % m_interval) == 0) || (wstarve[w] >= m_limit);
            take_live = !(pref && back_tag.size() > 0) && live_tag.size() > 0;
            if (take_live) begin
              {r.kind, r.handle} = live_tag[0];
              r.hash = live_hash[0];
              live_tag.delete(0);
              live_hash.delete(0);
            end else begin
              {r.kind, r.handle} = back_tag[0];
              r.hash = back_hash[0];
              back_tag.delete(0);
              back_hash.delete(0);
              r.bg = 1'b1;
            end
            if (take_live && back_tag.size() > 0) begin
              if (wstarve[w] != 8'hFF) wstarve[w]++;
            end else begin
              wstarve[w] = 0;
            end
            r.status = ST_GIVEN;
          end
        end
      end
      OP_COMPLETE: begin
        k = find_key(t, hash);
        if (k >= 0) key_vld[k] = 1'b0;
      end
      OP_REMOVE: begin
        for (int i = 0; i < KEY_N; i++)
          if (key_vld[i] && key_tag[i] == t) key_vld[i] = 1'b0;
        for (int i = live_tag.size() - 1; i >= 0; i--)
          if (live_tag[i] == t) begin
            live_tag.delete(i);
            live_hash.delete(i);
          end
        for (int i = back_tag.size() - 1; i >= 0; i--)
          if (back_tag[i] == t) begin
            back_tag.delete(i);
            back_hash.delete(i);
          end
      end
      OP_STOP: stopped = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // valid stays up after the accepting edge; the next action on the channel drives it
  task automatic send_job(logic [2:0] op, logic [4:0] wid, logic kind, logic [31:0] handle,
                          logic [63:0] hash, logic low);
    while (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      job_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    job_if.valid <= 1'b1;
    job_if.operation <= op;
    job_if.worker_id <= wid;
    job_if.job_kind <= kind;
    job_if.pipeline_handle <= handle;
    job_if.state_hash <= hash;
    job_if.is_low_priority <= low;
    @(posedge clk_i);
    while (!job_if.ready) @(posedge clk_i);
    expected_q = {expected_q, predict_queue(op, wid, kind, handle, hash, low)};
  endtask

  task automatic drain_results();
    job_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    // lane compaction after a pop or a remove can still be in flight
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    job_if.valid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PICK_INTERVAL) m_interval = val;
    else m_limit = val;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly recycled keys, sometimes fresh ones
  task automatic send_random_job(int pop_weight);
    int sel;
    int p;
    logic [2:0] op;
    sel = $urandom_range(99);
    p = $urandom_range(15);
    if (sel < 40) op = OP_PUSH;
    else if (sel < 40 + pop_weight) op = OP_POP;
    else if (sel < 90) op = OP_COMPLETE;
    else if (sel < 96) op = OP_REMOVE;
    else op = 3'($urandom_range(5, 7));
    if (op == OP_PUSH && $urandom_range(3) == 0) begin
      pool_tag[p] = {1'($urandom()), $urandom()};
      pool_hash[p] = rand64();
    end
    send_job(op, 5'($urandom()), pool_tag[p][32], pool_tag[p][31:0], pool_hash[p],
             1'($urandom()));
  endtask

  task automatic test_directed();
    send_job(OP_POP, 5'd0, 1'b0, 32'd0, 64'd0, 1'b0);   // empty
    send_job(OP_PUSH, 5'd0, 1'b0, 32'd0, 64'd0, 1'b0);
    send_job(OP_PUSH, 5'd0, 1'b0, 32'd0, 64'd0, 1'b1);  // duplicate
    send_job(OP_PUSH, 5'd31, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_job(OP_PUSH, 5'd0, 1'b1, 32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_job(OP_POP, 5'd31, 1'b0, 32'd0, 64'd0, 1'b0);
    send_job(OP_POP, 5'd7, 1'b0, 32'd0, 64'd0, 1'b0);
    send_job(OP_COMPLETE, 5'd0, 1'b0, 32'd0, 64'd0, 1'b0);
    send_job(OP_COMPLETE, 5'd0, 1'b0, 32'd0, 64'd0, 1'b0);  // unknown now
    send_job(OP_PUSH, 5'd0, 1'b0, 32'd0, 64'd0, 1'b1);
    send_job(OP_REMOVE, 5'd0, 1'b1, 32'hFFFF_FFFF, 64'd0, 1'b0);
    send_job(OP_REMOVE, 5'd0, 1'b0, 32'h1234_5678, 64'd0, 1'b0);  // unknown handle
    send_job(3'd5, 5'd3, 1'b1, 32'd1, 64'd1, 1'b1);
    send_job(3'd6, 5'd3, 1'b0, 32'd1, 64'd1, 1'b0);
    send_job(3'd7, 5'd3, 1'b1, 32'd1, 64'd1, 1'b1);
    send_job(OP_POP, 5'd1, 1'b0, 32'd0, 64'd0, 1'b0);
    send_job(OP_POP, 5'd1, 1'b0, 32'd0, 64'd0, 1'b0);
    send_job(OP_POP, 5'd1, 1'b0, 32'd0, 64'd0, 1'b0);
    drain_results();
  endtask

  // fill both lanes past depth and the key table, with the receiver held off
  task automatic test_fill_and_backpressure();
    rcv_hold = 300;
    for (int i = 0; i < 140; i++)
      send_job(OP_PUSH, 5'd0, 1'($urandom()), $urandom(), rand64(), i[0]);
    for (int i = 0; i < 140; i++)
      send_job(OP_POP, 5'($urandom()), 1'b0, 32'd0, 64'd0, 1'b0);
    drain_results();
  endtask

  task automatic test_aging(logic [7:0] interval, logic [7:0] limit);
    write_cfg(CFG_PICK_INTERVAL, interval);
    write_cfg(CFG_STARVATION_LIMIT, limit);
    for (int i = 0; i < 10; i++)
      send_job(OP_PUSH, 5'd0, 1'b0, $urandom(), rand64(), 1'b1);
    for (int i = 0; i < 20; i++)
      send_job(OP_PUSH, 5'd0, 1'b1, $urandom(), rand64(), 1'b0);
    for (int i = 0; i < 32; i++)
      send_job(OP_POP, 5'($urandom_range(2)), 1'b0, 32'd0, 64'd0, 1'b0);
    drain_results();
  endtask

  task automatic test_random(int n, int pop_weight);
    for (int i = 0; i < n; i++) send_random_job(pop_weight);
  endtask

  task automatic test_stop();
    send_job(OP_STOP, 5'd0, 1'b0, 32'd0, 64'd0, 1'b0);
    send_job(OP_PUSH, 5'd4, 1'b0, 32'h55, 64'h55, 1'b0);
    for (int i = 0; i < 30; i++) send_random_job(30);
    drain_results();
  endtask

  // receiver: random stalls plus a counted long hold-off
  always @(posedge clk_i) begin
    if (rcv_hold > 0) begin
      rcv_hold <= rcv_hold - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !(rcv_idle != 0 && $urandom_range(99) < rcv_idle);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.status, res_if.out_kind, res_if.out_handle, res_if.out_hash,
             res_if.from_background};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        n_checked++;
        if (want.status == ST_GIVEN) n_given++;
        if (got.status != want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.kind != want.kind)
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        if (got.handle != want.handle)
          $display("%0t: handle expected %h actual %h", $time, want.handle, got.handle);
        if (got.hash != want.hash)
          $display("%0t: hash expected %h actual %h", $time, want.hash, got.hash);
        if (got.bg != want.bg)
          $display("%0t: from_background expected %0d actual %0d", $time, want.bg, got.bg);
        if (got != want) errors++;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((job_if.valid && job_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    job_if.valid = 1'b0;
    job_if.operation = OP_PUSH;
    job_if.worker_id = '0;
    job_if.job_kind = 1'b0;
    job_if.pipeline_handle = '0;
    job_if.state_hash = '0;
    job_if.is_low_priority = 1'b0;
    res_if.ready = 1'b0;
    live_tag.delete();
    live_hash.delete();
    back_tag.delete();
    back_hash.delete();
    for (int i = 0; i < KEY_N; i++) key_vld[i] = 1'b0;
    for (int i = 0; i < WORK_N; i++) begin
      wpick_vld[i] = 1'b0;
      wstarve[i] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      pool_tag[i] = {1'($urandom()), $urandom()};
      pool_hash[i] = rand64();
    end
    start_pick = 1;
    stopped = 1'b0;
    m_interval = PickIntervalRst;
    m_limit = StarvationLimitRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle = 27;
    rcv_idle = 78;
    test_directed();
    test_fill_and_backpressure();
    test_aging(8'd1, 8'd255);
    test_aging(8'd255, 8'd1);
    test_aging(8'd0, 8'd0);
    test_aging(8'd3, 8'd2);
    test_random(90, 25);
    drain_results();
    snd_idle = 78;
    rcv_idle = 27;
    write_cfg(CFG_PICK_INTERVAL, 8'($urandom_range(1, 255)));
    write_cfg(CFG_STARVATION_LIMIT, 8'($urandom_range(1, 255)));
    test_random(80, 15);
    drain_results();
    snd_idle = 0;
    rcv_idle = 0;
    write_cfg(CFG_PICK_INTERVAL, 8'd4);
    write_cfg(CFG_STARVATION_LIMIT, 8'd5);
    test_random(60, 35);
    drain_results();
    test_stop();

    $display("Covered %0d result beats, %0d of them handed-out jobs, over several", n_checked,
             n_given);
    $display("aging settings, full lanes, output back-pressure and stop.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
